// ===== rtl/int8_fully_connected_layer_defines.svh =====
// ----------------------------------------------------------------------------
// int8 fully connected layer: assertion macros
// Shared property wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef INT8_FULLY_CONNECTED_LAYER_DEFINES_SVH
`define INT8_FULLY_CONNECTED_LAYER_DEFINES_SVH

// same-cycle implication
`define FCL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_pkg
// Types and constants shared by the fully connected layer modules.
// ----------------------------------------------------------------------------
package fcl_pkg;

  localparam int FCL_LANES           = 4;
  localparam int FCL_LANE_W          = 2;
  localparam int FCL_DEF_MAX_INPUTS  = 64;
  localparam int FCL_DEF_MAX_OUTPUTS = 64;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ACT    = 2'd2;
  localparam logic [1:0] CMD_RUN    = 2'd3;

  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] REG_RELU_ENABLE  = 2'd2;

  // activation token moving along the cell chain
  typedef struct packed {
    logic              valid;
    logic signed [7:0] act;
  } tok_t;

endpackage

// ===== rtl/fcl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_cell
// One MAC cell: owns the weight bank of its output lane, multiplies the
// passing activation by its weight and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module fcl_cell
  import fcl_pkg::*;
#(
  parameter int WDEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr,
  input  logic                      wr_en,
  input  logic [$clog2(WDEPTH)-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  tok_t                      in_tok,
  input  logic [$clog2(WDEPTH)-1:0] in_addr,
  output tok_t                      out_tok,
  output logic [$clog2(WDEPTH)-1:0] out_addr,
  output logic [31:0]               acc
);

  logic [7:0]         weight;
  logic signed [15:0] prod;

  fcl_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_wbank (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (in_addr),
    .rdata (weight)
  );

  // weight read lands together with the registered token
  assign prod = $signed(weight) * out_tok.act;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tok.valid <= 1'b0;
    end else begin
      out_tok.valid <= in_tok.valid;
    end
    out_tok.act <= in_tok.act;
    out_addr    <= in_addr;
    if (clr) begin
      acc <= '0;
    end else if (out_tok.valid) begin
      acc <= acc + {{16{prod[15]}}, prod};
    end
  end

endmodule

// ===== rtl/int8_fully_connected_layer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_fully_connected_layer
// int8 matrix-vector layer with bias and optional ReLU over a chain of MAC cells.
// ----------------------------------------------------------------------------
// channel | dir | tdata / tuser                            | tlast
// s_axis  | in  | row, col, value / cmd                    | -
// m_axis  | out | out_index, out_value                     | last
// cfg     | in  | cfg_we, cfg_index, cfg_data              | -
//
// Load items are accepted whenever the layer is idle. A run handles outputs in
// groups of four lanes: the inputs stream through the cell chain and drain,
// then each result takes a bias RAM read and an add; a stalled output holds
// the add. Input is held off for the whole run; the output register lets the
// next item in while the last result waits. Reset is synchronous and clears
// control only; the RAMs are undefined until written.
// ----------------------------------------------------------------------------
`include "int8_fully_connected_layer_defines.svh"

module int8_fully_connected_layer
  import fcl_pkg::*;
#(
  parameter int MAX_INPUTS  = FCL_DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = FCL_DEF_MAX_OUTPUTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // row_index[5:0], col_index[11:6], value[43:12]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_index[5:0], out_value[37:6]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int GROUPS    = (MAX_OUTPUTS + FCL_LANES - 1) / FCL_LANES;
  localparam int WDEPTH    = GROUPS * MAX_INPUTS;
  localparam int WAW       = $clog2(WDEPTH);
  localparam int AAW       = $clog2(MAX_INPUTS);
  localparam int BAW       = $clog2(MAX_OUTPUTS);
  localparam int IW        = $clog2(MAX_INPUTS + 1);
  localparam int OW        = $clog2(MAX_OUTPUTS + 1) + 1;
  localparam int DRAIN_CYC = FCL_LANES + 3;
  localparam int DW        = $clog2(DRAIN_CYC + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_STREAM, ST_DRAIN, ST_BIAS, ST_ADD
  } state_t;

  state_t        state;
  logic [6:0]    input_count;
  logic [6:0]    output_count;
  logic          relu_enable;
  logic [IW-1:0] n_in;
  logic [OW-1:0] n_out;
  logic          relu;
  logic [IW-1:0] col_cnt;
  logic [OW-1:0] row_cnt;
  logic [OW-1:0] row_next;
  logic [DW-1:0] wait_cnt;
  logic          clr;
  logic          feed_valid;
  tok_t          feed_tok;
  logic [WAW-1:0] feed_addr;

  logic [1:0]    cmd;
  logic [5:0]    in_row;
  logic [5:0]    in_col;
  logic [31:0]   in_value;
  logic          accept;
  logic          row_ok;
  logic          col_ok;
  logic [WAW-1:0] wr_addr;

  logic [7:0]    act_q;
  logic [31:0]   bias_q;
  logic [31:0]   sum;
  logic [FCL_LANE_W-1:0] lane;

  tok_t           tok_out  [FCL_LANES];
  logic [WAW-1:0] addr_out [FCL_LANES];
  logic [31:0]    acc      [FCL_LANES];

  assign cmd      = s_tuser;
  assign in_row   = s_tdata[5:0];
  assign in_col   = s_tdata[11:6];
  assign in_value = s_tdata[43:12];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign row_ok   = 32'(in_row) < MAX_OUTPUTS;
  assign col_ok   = 32'(in_col) < MAX_INPUTS;
  assign wr_addr  = WAW'(32'(in_row >> FCL_LANE_W) * MAX_INPUTS + 32'(in_col));
  assign lane     = row_cnt[FCL_LANE_W-1:0];
  assign row_next = row_cnt + OW'(1);
  assign sum      = acc[lane] + bias_q;

  // activation read lands in the same cycle as its feed address
  assign feed_tok.valid = feed_valid;
  assign feed_tok.act   = act_q;

  // stores
  fcl_ram #(.WIDTH(8), .DEPTH(MAX_INPUTS)) u_act_ram (
    .clk   (clk),
    .we    (accept && cmd == CMD_ACT && col_ok),
    .waddr (AAW'(in_col)),
    .wdata (in_value[7:0]),
    .raddr (col_cnt[AAW-1:0]),
    .rdata (act_q)
  );

  fcl_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
    .clk   (clk),
    .we    (accept && cmd == CMD_BIAS && row_ok),
    .waddr (BAW'(in_row)),
    .wdata (in_value),
    .raddr (row_cnt[BAW-1:0]),
    .rdata (bias_q)
  );

  // cell chain, one output lane per cell
  for (genvar k = 0; k < FCL_LANES; k++) begin : g_cell
    tok_t           c_tok;
    logic [WAW-1:0] c_addr;
    if (k == 0) begin : g_head
      assign c_tok  = feed_tok;
      assign c_addr = feed_addr;
    end else begin : g_body
      assign c_tok  = tok_out[k-1];
      assign c_addr = addr_out[k-1];
    end
    fcl_cell #(.WDEPTH(WDEPTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .wr_en    (accept && cmd == CMD_WEIGHT && row_ok && col_ok &&
                 in_row[FCL_LANE_W-1:0] == FCL_LANE_W'(k)),
      .wr_addr  (wr_addr),
      .wr_data  (in_value[7:0]),
      .in_tok   (c_tok),
      .in_addr  (c_addr),
      .out_tok  (tok_out[k]),
      .out_addr (addr_out[k]),
      .acc      (acc[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      input_count  <= 7'd1;
      output_count <= 7'd1;
      relu_enable  <= 1'b0;
      clr          <= 1'b0;
      feed_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      clr        <= 1'b0;
      feed_valid <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INPUT_COUNT:  input_count  <= cfg_data;
          REG_OUTPUT_COUNT: output_count <= cfg_data;
          REG_RELU_ENABLE:  relu_enable  <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept && cmd == CMD_RUN) begin
            n_in    <= (32'(input_count) > MAX_INPUTS) ? IW'(MAX_INPUTS)
                                                       : IW'(input_count);
            n_out   <= (32'(output_count) > MAX_OUTPUTS) ? OW'(MAX_OUTPUTS)
                                                         : OW'(output_count);
            relu    <= relu_enable;
            row_cnt <= '0;
            col_cnt <= '0;
            if (output_count != 7'd0) begin
              clr   <= 1'b1;
              state <= ST_STREAM;
            end
          end
        end
        ST_STREAM: begin
          if (col_cnt == n_in) begin
            wait_cnt <= DW'(DRAIN_CYC);
            state    <= ST_DRAIN;
          end else begin
            feed_valid <= 1'b1;
            feed_addr <= WAW'(32'(row_cnt >> FCL_LANE_W) * MAX_INPUTS + 32'(col_cnt));
            col_cnt   <= col_cnt + IW'(1);
          end
        end
        ST_DRAIN: begin
          wait_cnt <= wait_cnt - DW'(1);
          if (wait_cnt == '0) begin
            state <= ST_BIAS;
          end
        end
        ST_BIAS: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            m_tdata[5:0]  <= 6'(row_cnt);
            m_tdata[37:6] <= (relu && sum[31]) ? 32'd0 : sum;
            m_tdata[39:38] <= 2'b00;
            m_tlast       <= (row_next == n_out);
            row_cnt       <= row_next;
            if (row_next == n_out) begin
              state <= ST_IDLE;
            end else if (row_next[FCL_LANE_W-1:0] == '0) begin
              clr     <= 1'b1;
              col_cnt <= '0;
              state   <= ST_STREAM;
            end else begin
              state <= ST_BIAS;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `FCL_ASSERT_NXT(a_add_loads, state == ST_ADD && (!m_tvalid || m_tready), m_tvalid, "result not loaded")
  `FCL_ASSERT_IMP(a_feed_in_stream, feed_tok.valid, $past(state) == ST_STREAM, "token outside streaming")
  `FCL_ASSERT_IMP(a_row_in_range, state == ST_ADD, row_cnt < n_out, "row beyond output count")
  `FCL_ASSERT_IMP(a_chain_drained, tok_out[FCL_LANES-1].valid, state == ST_STREAM || state == ST_DRAIN, "token left in chain")

endmodule
